/* hdl/datv_pkg.sv */
`timescale 1ns / 1ps
// Package for the decaying additive tone voice: default parameter values,
// register reset values, configuration index codes and the sine table generator.
// Depends on nothing; the ROM and the top level import it.
package datv_pkg;

    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF    = 16;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 24;
    localparam int RELEASE_BITS   = 16;
    localparam int RECIP_BITS     = 24;
    localparam int COUNT_BITS     = 16;
    localparam int PHASE_BITS     = 33;
    localparam int STEP_BITS      = 32;
    localparam int OUT_BITS       = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RECIP   = 1'b1;

    localparam logic [RELEASE_BITS-1:0] RELEASE_RESET = 16'd19845;
    localparam logic [RECIP_BITS-1:0]   RECIP_RESET   = 24'd845;
    localparam logic [COUNT_BITS-1:0]   COUNT_MAX     = 16'hFFFF;
    localparam logic [OUT_BITS-1:0]     SAMPLE_MAX    = 16'd32767;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // Table entry k: round(amp * sin(theta_k)), the sine being a truncating
    // Taylor sum in Q30. Evaluated only at elaboration.
    function automatic logic [63:0] sine_entry(input logic [63:0] k, input int addr_bits,
                                               input int sample_bits);
        logic [63:0]        amp;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        s;
        amp  = (64'd1 << (sample_bits - 1)) - 64'd1;
        x    = (PI_Q30 * k) >> (addr_bits - 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd342; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd420; sum = sum + signed'(term);
        if (sum < 0) begin
            s = 64'd0;
        end else if (unsigned'(sum) > ONE_Q30) begin
            s = ONE_Q30;
        end else begin
            s = unsigned'(sum);
        end
        return (s * amp + (ONE_Q30 >> 1)) >> 30;
    endfunction

endpackage

/* hdl/datv_sine_rom.sv */
`timescale 1ns / 1ps
// Quarter-wave sine ROM with a registered read port.
// Depends on datv_pkg for the table generator.
module datv_sine_rom #(
    parameter int SINE_ADDR_BITS = datv_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS    = datv_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic [SINE_ADDR_BITS-2:0] i_addr,
    output logic [SAMPLE_BITS-2:0]    o_data
);
    import datv_pkg::*;

    localparam int QUARTER = 2 ** (SINE_ADDR_BITS - 2);

    logic [SAMPLE_BITS-2:0] w_table [QUARTER+1];
    logic [SAMPLE_BITS-2:0] r_data;

    for (genvar k = 0; k <= QUARTER; k++) begin : g_entry
        localparam logic [63:0] ENTRY = sine_entry(64'(k), SINE_ADDR_BITS, SAMPLE_BITS);
        assign w_table[k] = ENTRY[SAMPLE_BITS-2:0];
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_table[i_addr];
    end

    assign o_data = r_data;

endmodule

/* hdl/decaying_additive_tone_voice.sv */
`timescale 1ns / 1ps
// Decaying additive tone voice: top level with the sequencer and shared multiplier.
// Depends on datv_pkg and datv_sine_rom.
//
// One input transfer is one audio sample tick, and each tick gives exactly one
// output transfer. A sounding sample passes through every step of the sequence,
// and the next input transfer is taken only once the block is idle again. A silent
// sample goes from the release check straight to the output step. The result reaches
// the output register in the same cycle that ready returns. The sequence runs through
// the single registered multiplier, which forms the envelope gain while the one-port
// sine ROM is read three times, then the enveloped sum and the reciprocal divisions
// by three and by the table amplitude in turn. A result that is still waiting in the
// output register holds the sequencer in its last step until that transfer is taken.
// The output register lets the next input transfer be taken while a result still
// waits. Configuration writes are always taken and are meant for idle time.
module decaying_additive_tone_voice #(
    parameter int SINE_ADDR_BITS = datv_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS    = datv_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [datv_pkg::STEP_BITS-1:0]      i_phase_step,
    input  logic                                i_note_start,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [datv_pkg::OUT_BITS-1:0] o_sample,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [datv_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [datv_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import datv_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int QUARTER = 2 ** (SINE_ADDR_BITS - 2);
    localparam int ROM_AW  = SINE_ADDR_BITS - 1;
    localparam int DATA_W  = SB - 1;
    localparam int SUM_W   = SB + 2;
    localparam int MAG_W   = SB + 1;
    localparam int GAIN_W  = 25;
    localparam int P_W     = MAG_W + GAIN_W;
    localparam int V_W     = SB + 1;
    localparam int K3      = V_W;
    localparam int Q3_W    = SB;
    localparam int M_W     = SB - 1;
    localparam int D_W     = SB + 14;
    localparam int KA      = D_W;
    localparam int QA_W    = 16;
    localparam int A_W     = D_W;
    localparam int B_W     = GAIN_W;
    localparam int PROD_W  = A_W + B_W;

    localparam logic [63:0]       AMP64    = (64'd1 << (SB - 1)) - 64'd1;
    localparam logic [Q3_W-1:0]   M3       = Q3_W'((64'd1 << K3) / 64'd3);
    localparam logic [QA_W-1:0]   MA       = QA_W'((64'd1 << KA) / AMP64);
    localparam logic [D_W-1:0]    HALF_AMP = D_W'(AMP64 >> 1);
    localparam logic [D_W:0]      AMP_D    = (D_W + 1)'(AMP64);
    localparam logic [GAIN_W-1:0] UNITY    = GAIN_W'(64'd1 << 24);
    localparam logic [P_W:0]      ROUND3   = (P_W + 1)'(64'd3 << 23);
    localparam logic [SB+1:0]     THREE    = (SB + 2)'(3);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_P1, S_P2, S_SUM, S_MAG, S_DIV3, S_FIX3, S_SCALE, S_FIXA, S_OUT
    } t_state;

    t_state                r_state;
    logic [PHASE_BITS-1:0] r_phase;
    logic [COUNT_BITS-1:0] r_count;
    logic [RELEASE_BITS-1:0] r_release;
    logic [RECIP_BITS-1:0] r_recip;
    logic [SUM_W-1:0]      r_sum;
    logic [GAIN_W-1:0]     r_gain;
    logic                  r_neg;
    logic                  r_part_neg;
    logic [V_W-1:0]        r_v;
    logic [M_W-1:0]        r_m;
    logic [D_W-1:0]        r_d;
    logic [PROD_W-1:0]     r_prod;
    logic [OUT_BITS-1:0]   r_res;
    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_sample;

    logic [STEP_BITS-1:0]  w_part;
    logic [ROM_AW-1:0]     w_rom_addr;
    logic [DATA_W-1:0]     w_rom_data;
    logic [SUM_W-1:0]      w_ext;
    logic [SUM_W-1:0]      w_part_val;
    logic [MAG_W-1:0]      w_mag;
    logic [COUNT_BITS-1:0] w_diff;
    logic [GAIN_W-1:0]     w_gain;
    logic [P_W:0]          w_round;
    logic [V_W-1:0]        w_v;
    logic [Q3_W-1:0]       w_q3;
    logic [SB+1:0]         w_three_q3;
    logic [SB+1:0]         w_rem3;
    logic [Q3_W-1:0]       w_m_full;
    logic [D_W-1:0]        w_d;
    logic [QA_W-1:0]       w_qa;
    logic [D_W:0]          w_qa_amp;
    logic [D_W:0]          w_rem_a;
    logic [QA_W:0]         w_y;
    logic [OUT_BITS-1:0]   w_y_sat;
    logic [A_W-1:0]        w_mul_a;
    logic [B_W-1:0]        w_mul_b;
    logic                  w_accept;

    assign w_accept    = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_sample    = signed'(r_sample);

    always_comb begin
        unique case (r_state)
            S_CHECK: w_part = r_phase[32:1];
            S_P1:    w_part = r_phase[31:0];
            S_P2:    w_part = {r_phase[30:0], 1'b0};
            default: w_part = r_phase[31:0];
        endcase
    end

    assign w_rom_addr = w_part[30]
        ? ROM_AW'(QUARTER) - {1'b0, w_part[31-2 -: SINE_ADDR_BITS-2]}
        : {1'b0, w_part[31-2 -: SINE_ADDR_BITS-2]};

    datv_sine_rom #(
        .SINE_ADDR_BITS(SINE_ADDR_BITS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_rom (
        .i_clk (i_clk),
        .i_addr(w_rom_addr),
        .o_data(w_rom_data)
    );

    assign w_ext      = {{(SUM_W - DATA_W){1'b0}}, w_rom_data};
    assign w_part_val = r_part_neg ? (SUM_W'(0) - w_ext) : w_ext;
    assign w_mag      = r_sum[SUM_W-1] ? MAG_W'(SUM_W'(0) - r_sum) : MAG_W'(r_sum);
    assign w_diff     = r_release - r_count;
    assign w_gain     = (r_prod > PROD_W'(UNITY)) ? UNITY : r_prod[GAIN_W-1:0];

    assign w_round    = {1'b0, r_prod[P_W-1:0]} + ROUND3;
    assign w_v        = w_round[24 +: V_W];
    assign w_q3       = r_prod[K3 +: Q3_W];
    assign w_three_q3 = ((SB + 2)'(w_q3) << 1) + (SB + 2)'(w_q3);
    assign w_rem3     = (SB + 2)'(r_v) - w_three_q3;
    assign w_m_full   = w_q3 + Q3_W'(w_rem3 >= THREE);

    assign w_d        = {r_m, 15'b0} - D_W'(r_m) + HALF_AMP;
    assign w_qa       = r_prod[KA +: QA_W];
    assign w_qa_amp   = {w_qa, {(SB - 1){1'b0}}} - (D_W + 1)'(w_qa);
    assign w_rem_a    = {1'b0, r_d} - w_qa_amp;
    assign w_y        = {1'b0, w_qa} + (QA_W + 1)'(w_rem_a >= AMP_D);
    assign w_y_sat    = (w_y > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX : w_y[OUT_BITS-1:0];

    always_comb begin
        unique case (r_state)
            S_CHECK: begin
                w_mul_a = A_W'(w_diff);
                w_mul_b = B_W'(r_recip);
            end
            S_MAG: begin
                w_mul_a = A_W'(w_mag);
                w_mul_b = r_gain;
            end
            S_DIV3: begin
                w_mul_a = A_W'(w_v);
                w_mul_b = B_W'(M3);
            end
            S_SCALE: begin
                w_mul_a = w_d;
                w_mul_b = B_W'(MA);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= w_mul_a * w_mul_b;
        r_part_neg <= w_part[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release <= RELEASE_RESET;
            r_recip   <= RECIP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RELEASE: r_release <= i_cfg_data[RELEASE_BITS-1:0];
                CFG_RECIP:   r_recip   <= i_cfg_data[RECIP_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_count     <= COUNT_MAX;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
                r_sample    <= r_res;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_note_start) begin
                            r_count <= COUNT_BITS'(1);
                            r_phase <= PHASE_BITS'(i_phase_step);
                        end else begin
                            if (r_count != COUNT_MAX) begin
                                r_count <= r_count + COUNT_BITS'(1);
                            end
                            r_phase <= r_phase + PHASE_BITS'(i_phase_step);
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_count >= r_release) begin
                        r_res   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_P1;
                    end
                end
                S_P1: begin
                    r_sum   <= w_part_val;
                    r_gain  <= w_gain;
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_sum   <= r_sum + w_part_val;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= r_sum + w_part_val;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_state <= S_DIV3;
                end
                S_DIV3: begin
                    r_v     <= w_v;
                    r_state <= S_FIX3;
                end
                S_FIX3: begin
                    r_m     <= w_m_full[M_W-1:0];
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_d     <= w_d;
                    r_state <= S_FIXA;
                end
                S_FIXA: begin
                    r_res   <= r_neg ? (OUT_BITS'(0) - w_y_sat) : w_y_sat;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("Input was accepted while a tick was still in progress.");

    a_count_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_count != '0))
        else $error("Sample counter is zero after a tick.");

    a_div3_correction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX3) |-> (w_rem3 < (SB + 2)'(6)))
        else $error("Division by three left a remainder out of range.");

    a_amp_correction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIXA) |-> (w_rem_a < (AMP_D << 1)))
        else $error("Division by the amplitude left a remainder out of range.");

endmodule
